[src/masked_linear_regression_fit_core_macros.svh]
// Assertion macros for the masked linear regression fit core.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef MASKED_LINEAR_REGRESSION_FIT_CORE_MACROS_SVH
`define MASKED_LINEAR_REGRESSION_FIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MLR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");
`define MLR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define MLR_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define MLR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

[src/mlr_pkg.sv]
// Shared types, constants and helper functions of the masked linear regression fit core.
// No dependencies.
package mlr_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int WIDE_W     = 128;
    localparam int ITER_W     = 8;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [ITER_W-1:0] iters;
    } t_alu_req;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

[src/masked_linear_regression_fit_core.sv]
// Top level of the masked linear regression fit core: sequencer and accumulators.
// Depends on mlr_pkg, mlr_alu and masked_linear_regression_fit_core_macros.svh.
//
// A pixel is transferred at a rising edge with start high and busy low. A kept
// pixel then holds busy high while one shared unit works: the mean division
// takes 40 steps and each of the two products 24 steps, each operation
// followed by a handoff; a skipped pixel without the last mark leaves busy low.
// A pixel carrying the last mark then solves the line: six 64-step products,
// a check state and two 128-step divisions through the same unit.
// The result appears on o_fit_slope, o_fit_offset and o_fit_ok for exactly
// one cycle marked by o_valid, while busy is already low again; the receiver
// cannot stall it. A rejected fit skips the divisions and gives zeros with
// o_fit_ok low.
// After the result the sums are cleared for the next data set.
// Synchronous reset clears the sums and returns the sequencer to idle.
`include "masked_linear_regression_fit_core_macros.svh"
module masked_linear_regression_fit_core import mlr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_model_value,
    input  logic signed [39:0] i_data_sum,
    input  logic [15:0]        i_hit_count,
    input  logic               i_pixel_unmasked,
    input  logic               i_last_pixel,
    output logic               o_valid,
    output logic signed [47:0] o_fit_slope,
    output logic signed [23:0] o_fit_offset,
    output logic               o_fit_ok
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PDIV  = 8'b00000010,
        S_PSQ   = 8'b00000100,
        S_PXY   = 8'b00001000,
        S_SMUL  = 8'b00010000,
        S_CHECK = 8'b00100000,
        S_DIV1  = 8'b01000000,
        S_DIV2  = 8'b10000000
    } t_state;

    t_state             r_state, n_state;
    logic               r_go, n_go;
    logic [2:0]         r_step;
    logic signed [23:0] r_x;
    logic [39:0]        r_dsum;
    logic [15:0]        r_hits;
    logic               r_last;
    logic [23:0]        r_y;
    logic [16:0]        r_used;
    logic [39:0]        r_sx;
    logic [39:0]        r_sy;
    logic [63:0]        r_sxx;
    logic [63:0]        r_sxy;
    logic [WIDE_W-1:0]  r_t;
    logic [WIDE_W-1:0]  r_den;
    logic [WIDE_W-1:0]  r_num;
    logic [WIDE_W-1:0]  r_on;
    logic               r_valid;
    logic [47:0]        r_slope;
    logic [23:0]        r_offset;
    logic               r_ok;

    t_alu_req           alu_req;
    logic [WIDE_W-1:0]  alu_a;
    logic [WIDE_W-1:0]  alu_b;
    logic               alu_done;
    logic [WIDE_W-1:0]  alu_res;

    logic               keep;
    logic [39:0]        dmag;
    logic [63:0]        x64;
    logic [63:0]        y64;
    logic [63:0]        n64;
    logic [63:0]        sx64;
    logic [63:0]        sy64;
    logic [WIDE_W-1:0]  diff;
    logic [23:0]        y_sat;
    logic [47:0]        slope_sat;
    logic [23:0]        off_sat;
    logic               fit_good;

    assign keep = i_pixel_unmasked && (i_hit_count != 16'd0)
                  && (r_used < 17'(MAX_PIXELS));
    assign dmag = r_dsum[39] ? (~r_dsum + 40'd1) : r_dsum;
    assign x64  = {{40{r_x[23]}}, r_x};
    assign y64  = {{40{r_y[23]}}, r_y};
    assign n64  = {47'd0, r_used};
    assign sx64 = {{24{r_sx[39]}}, r_sx};
    assign sy64 = {{24{r_sy[39]}}, r_sy};
    assign diff = r_t - alu_res;
    assign fit_good = (r_den != '0) && !r_den[WIDE_W-1] && (r_num != '0) && !r_num[WIDE_W-1];

    always_comb begin
        if (r_dsum[39]) begin
            y_sat = (alu_res[39:0] > 40'h800000) ? 24'h800000 : (~alu_res[23:0] + 24'd1);
        end else begin
            y_sat = (alu_res[39:23] != '0) ? 24'h7FFFFF : alu_res[23:0];
        end
        slope_sat = (alu_res[WIDE_W-1:47] != '0) ? 48'h7FFFFFFFFFFF : alu_res[47:0];
        if (r_on[WIDE_W-1]) begin
            off_sat = ((alu_res[WIDE_W-1:24] != '0) || (alu_res[23:0] > 24'h800000))
                      ? 24'h800000 : (~alu_res[23:0] + 24'd1);
        end else begin
            off_sat = (alu_res[WIDE_W-1:23] != '0) ? 24'h7FFFFF : alu_res[23:0];
        end
    end

    always_comb begin
        alu_req.start = r_go;
        alu_req.op    = OP_MUL;
        alu_req.iters = ITER_W'(64);
        alu_a         = '0;
        alu_b         = '0;
        unique case (r_state)
            S_PDIV: begin
                alu_req.op    = OP_DIV;
                alu_req.iters = ITER_W'(40);
                alu_a         = {dmag, 88'd0};
                alu_b         = {112'd0, r_hits};
            end
            S_PSQ: begin
                alu_req.iters = ITER_W'(24);
                alu_a         = {64'd0, x64};
                alu_b         = {64'd0, x64};
            end
            S_PXY: begin
                alu_req.iters = ITER_W'(24);
                alu_a         = {64'd0, x64};
                alu_b         = {64'd0, y64};
            end
            S_SMUL: begin
                unique case (r_step)
                    3'd0: begin alu_a = {64'd0, n64};   alu_b = {64'd0, r_sxx}; end
                    3'd1: begin alu_a = {64'd0, sx64};  alu_b = {64'd0, sx64};  end
                    3'd2: begin alu_a = {64'd0, n64};   alu_b = {64'd0, r_sxy}; end
                    3'd3: begin alu_a = {64'd0, sx64};  alu_b = {64'd0, sy64};  end
                    3'd4: begin alu_a = {64'd0, r_sxx}; alu_b = {64'd0, sy64};  end
                    default: begin alu_a = {64'd0, sx64}; alu_b = {64'd0, r_sxy}; end
                endcase
            end
            S_DIV1: begin
                alu_req.op    = OP_DIV;
                alu_req.iters = ITER_W'(WIDE_W);
                alu_a         = {r_num[WIDE_W-25:0], 24'd0};
                alu_b         = r_den;
            end
            S_DIV2: begin
                alu_req.op    = OP_DIV;
                alu_req.iters = ITER_W'(WIDE_W);
                alu_a         = r_on[WIDE_W-1] ? (~r_on + WIDE_W'(1)) : r_on;
                alu_b         = r_den;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    mlr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (keep) begin
                        n_state = S_PDIV;
                        n_go    = 1'b1;
                    end else if (i_last_pixel) begin
                        n_state = S_SMUL;
                        n_go    = 1'b1;
                    end
                end
            end
            S_PDIV: begin
                if (alu_done) begin
                    n_state = S_PSQ;
                    n_go    = 1'b1;
                end
            end
            S_PSQ: begin
                if (alu_done) begin
                    n_state = S_PXY;
                    n_go    = 1'b1;
                end
            end
            S_PXY: begin
                if (alu_done) begin
                    n_state = r_last ? S_SMUL : S_IDLE;
                    n_go    = r_last;
                end
            end
            S_SMUL: begin
                if (alu_done) begin
                    n_state = (r_step == 3'd5) ? S_CHECK : S_SMUL;
                    n_go    = (r_step != 3'd5);
                end
            end
            S_CHECK: begin
                n_state = fit_good ? S_DIV1 : S_IDLE;
                n_go    = fit_good;
            end
            S_DIV1: begin
                if (alu_done) begin
                    n_state = S_DIV2;
                    n_go    = 1'b1;
                end
            end
            S_DIV2: begin
                if (alu_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= 3'd0;
            r_used  <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= (r_state == S_CHECK && !fit_good) || (r_state == S_DIV2 && alu_done);
            if (r_state == S_IDLE) begin
                r_step <= 3'd0;
            end else if (r_state == S_SMUL && alu_done) begin
                r_step <= r_step + 3'd1;
            end
            if (r_state == S_PSQ && alu_done) begin
                r_sxx <= r_sxx + alu_res[63:0];
            end
            if (r_state == S_PXY && alu_done) begin
                r_sxy  <= r_sxy + alu_res[63:0];
                r_used <= r_used + 17'd1;
                r_sx   <= r_sx + {{16{r_x[23]}}, r_x};
                r_sy   <= r_sy + {{16{r_y[23]}}, r_y};
            end
            if ((r_state == S_CHECK && !fit_good) || (r_state == S_DIV2 && alu_done)) begin
                r_used  <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_x    <= i_model_value;
            r_dsum <= i_data_sum;
            r_hits <= i_hit_count;
            r_last <= i_last_pixel;
        end
        if (r_state == S_PDIV && alu_done) begin
            r_y <= y_sat;
        end
        if (r_state == S_SMUL && alu_done) begin
            unique case (r_step)
                3'd1:    r_den <= diff;
                3'd3:    r_num <= diff;
                3'd5:    r_on  <= diff;
                default: r_t   <= alu_res;
            endcase
        end
        if (r_state == S_CHECK && !fit_good) begin
            r_slope  <= '0;
            r_offset <= '0;
            r_ok     <= 1'b0;
        end
        if (r_state == S_DIV1 && alu_done) begin
            r_slope <= slope_sat;
        end
        if (r_state == S_DIV2 && alu_done) begin
            r_offset <= off_sat;
            r_ok     <= 1'b1;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_fit_slope  = r_slope;
    assign o_fit_offset = r_offset;
    assign o_fit_ok     = r_ok;

    `MLR_ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `MLR_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `MLR_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, o_valid && !o_fit_ok,
                      o_fit_slope == 48'sd0 && o_fit_offset == 24'sd0)
    `MLR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
                     start && !busy && (keep || i_last_pixel), busy)

endmodule

[src/mlr_alu.sv]
// Shared iterative unit: shift-add signed multiply and restoring unsigned divide.
// Depends on mlr_pkg.
module mlr_alu import mlr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [WIDE_W-1:0] i_a,
    input  logic [WIDE_W-1:0] i_b,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_res
);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    t_op               r_op;
    logic              r_neg;
    logic [WIDE_W-1:0] r_a;
    logic [WIDE_W-1:0] r_b;
    logic [WIDE_W-1:0] r_acc;
    logic [WIDE_W-1:0] r_q;
    logic [WIDE_W-1:0] r_res;

    logic [WIDE_W-1:0] rem_sh;
    logic [WIDE_W-1:0] rem_sub;
    logic              rem_ge;
    logic [WIDE_W-1:0] acc_add;

    assign rem_sh  = {r_acc[WIDE_W-2:0], r_a[WIDE_W-1]};
    assign rem_ge  = rem_sh >= r_b;
    assign rem_sub = rem_sh - r_b;
    assign acc_add = r_acc + r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_req.start && r_busy && (r_cnt == ITER_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.iters;
            r_op  <= i_req.op;
            r_acc <= '0;
            r_q   <= '0;
            if (i_req.op == OP_MUL) begin
                r_a   <= {64'd0, mag64(i_a[63:0])};
                r_b   <= {64'd0, mag64(i_b[63:0])};
                r_neg <= i_a[63] ^ i_b[63];
            end else begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - ITER_W'(1);
            r_a   <= {r_a[WIDE_W-2:0], 1'b0};
            unique case (r_op)
                OP_MUL: begin
                    r_b <= {1'b0, r_b[WIDE_W-1:1]};
                    if (r_b[0]) begin
                        r_acc <= acc_add;
                    end
                end
                OP_DIV: begin
                    r_acc <= rem_ge ? rem_sub : rem_sh;
                    r_q   <= {r_q[WIDE_W-2:0], rem_ge};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
        if (r_fin) begin
            if (r_op == OP_MUL) begin
                r_res <= r_neg ? (~r_acc + WIDE_W'(1)) : r_acc;
            end else begin
                r_res <= r_q;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
